// ----- hdl/pdea_pkg.sv -----
package pdea_pkg;

  // Store depth and coefficient width.
  localparam int MAX_DETS  = 256;
  localparam int COEF_BITS = 16;

  // Field and register widths that the interface fixes.
  localparam int ORB_W     = 8;
  localparam int SLOT_W    = 8;
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 48;

  // Derived widths.
  localparam int ADDR_W = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int CNT_W  = $clog2(MAX_DETS + 1);

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_BRA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_KET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BRA_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KET_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_PARTICLE = 2'd2;

  typedef struct packed {
    logic        [CMD_W-1:0]     command;
    logic        [SLOT_W-1:0]    slot;
    logic        [ORB_W-1:0]     orbital_first;
    logic        [ORB_W-1:0]     orbital_second;
    logic signed [COEF_BITS-1:0] coef_re;
    logic signed [COEF_BITS-1:0] coef_im;
    logic        [ORB_W-1:0]     op_p;
    logic        [ORB_W-1:0]     op_q;
    logic        [ORB_W-1:0]     op_r;
    logic        [ORB_W-1:0]     op_s;
  } req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] element_re;
    logic signed [ACC_W-1:0] element_im;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_bra;
    logic              load_ket;
    logic              start;
    logic              rd_valid;
    logic [ADDR_W-1:0] bra_addr;
    logic [ADDR_W-1:0] ket_addr;
    logic              finish;
    logic              two_particle;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic res_free;
  } dp_status_t;

endpackage

// ----- hdl/pdea_ctrl.sv -----
module pdea_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [pdea_pkg::CMD_W-1:0]    command,
  input  logic                          cfg_write,
  input  logic [pdea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdea_pkg::CFG_W-1:0]    cfg_data,
  input  pdea_pkg::dp_status_t          status,
  output pdea_pkg::ctl_cmd_t            cmd
);
  import pdea_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t              state;
  logic [COUNT_W-1:0]  bra_count;
  logic [COUNT_W-1:0]  ket_count;
  logic                two_particle;
  logic [ADDR_W-1:0]   bra_idx;
  logic [ADDR_W-1:0]   ket_idx;

  logic [CNT_W-1:0]    nb_eff;
  logic [CNT_W-1:0]    nk_eff;
  logic                accept;
  logic                ket_last;
  logic                bra_last;
  logic                empty_walk;

  // Counts above the store depth act as the full depth.
  assign nb_eff = (32'(bra_count) > 32'(MAX_DETS)) ? CNT_W'(MAX_DETS) : CNT_W'(bra_count);
  assign nk_eff = (32'(ket_count) > 32'(MAX_DETS)) ? CNT_W'(MAX_DETS) : CNT_W'(ket_count);

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign ket_last   = (CNT_W'(ket_idx) + CNT_W'(1)) == nk_eff;
  assign bra_last   = (CNT_W'(bra_idx) + CNT_W'(1)) == nb_eff;
  assign empty_walk = (nb_eff == '0) || (nk_eff == '0);

  always_comb begin
    cmd              = '0;
    cmd.load_bra     = accept && (command == CMD_LOAD_BRA);
    cmd.load_ket     = accept && (command == CMD_LOAD_KET);
    cmd.start        = accept && (command == CMD_QUERY);
    cmd.rd_valid     = (state == S_RUN);
    cmd.bra_addr     = bra_idx;
    cmd.ket_addr     = ket_idx;
    cmd.finish       = (state == S_DRAIN) && !status.busy && status.res_free;
    cmd.two_particle = two_particle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bra_count    <= '0;
      ket_count    <= '0;
      two_particle <= 1'b0;
      bra_idx      <= '0;
      ket_idx      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BRA_COUNT:    bra_count    <= cfg_data[COUNT_W-1:0];
          REG_KET_COUNT:    ket_count    <= cfg_data[COUNT_W-1:0];
          REG_TWO_PARTICLE: two_particle <= cfg_data[0];
          default:          ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          bra_idx <= '0;
          ket_idx <= '0;
          if (accept && (command == CMD_QUERY)) begin
            state <= empty_walk ? S_DRAIN : S_RUN;
          end
        end
        S_RUN: begin
          if (ket_last) begin
            ket_idx <= '0;
            if (bra_last) begin
              state <= S_DRAIN;
            end else begin
              bra_idx <= bra_idx + ADDR_W'(1);
            end
          end else begin
            ket_idx <= ket_idx + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> (CNT_W'(bra_idx) < nb_eff) && (CNT_W'(ket_idx) < nk_eff))
    else $error("pair index outside the configured counts");

  a_finish_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !status.busy)
    else $error("result taken while the pipeline still holds pairs");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && ket_last && bra_last) |=> state == S_DRAIN)
    else $error("walk did not end after the last pair");

endmodule

// ----- hdl/pdea_dp.sv -----
module pdea_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pdea_pkg::req_t       req,
  input  pdea_pkg::ctl_cmd_t   cmd,
  output pdea_pkg::dp_status_t status,
  output logic                 res_valid,
  input  logic                 res_stall,
  output pdea_pkg::res_t       res
);
  import pdea_pkg::*;

  localparam int PROD_W = 2 * COEF_BITS;
  localparam int PSUM_W = PROD_W + 1;
  localparam int TERM_W = PROD_W + 3;
  localparam int SUM_W  = ACC_W + 1;

  typedef struct packed {
    logic        [ORB_W-1:0]     orb_a;
    logic        [ORB_W-1:0]     orb_b;
    logic signed [COEF_BITS-1:0] re;
    logic signed [COEF_BITS-1:0] im;
  } det_t;

  // Signed weight of one bra-ket pair from the orbital equality pattern.
  function automatic logic signed [2:0] pair_weight(
    input det_t x, input det_t y, input logic tp,
    input logic [ORB_W-1:0] p, input logic [ORB_W-1:0] q,
    input logic [ORB_W-1:0] r, input logic [ORB_W-1:0] s);
    logic t0, t1, t2, t3;
    begin
      if (tp) begin
        t0 = (x.orb_b == p) && (x.orb_a == q) && (y.orb_a == s) && (y.orb_b == r);
        t1 = (x.orb_b == p) && (x.orb_a == q) && (y.orb_b == s) && (y.orb_a == r);
        t2 = (x.orb_b == q) && (x.orb_a == p) && (y.orb_a == s) && (y.orb_b == r);
        t3 = (x.orb_b == q) && (x.orb_a == p) && (y.orb_b == s) && (y.orb_a == r);
      end else begin
        t0 = (x.orb_b == p) && (x.orb_a == y.orb_a) && (y.orb_b == q);
        t1 = (x.orb_b == p) && (x.orb_a == y.orb_b) && (y.orb_a == q);
        t2 = (x.orb_b == y.orb_a) && (x.orb_a == p) && (y.orb_b == q);
        t3 = (x.orb_b == y.orb_b) && (x.orb_a == p) && (y.orb_a == q);
      end
      pair_weight = $signed({2'b00, t0}) - $signed({2'b00, t1})
                  - $signed({2'b00, t2}) + $signed({2'b00, t3});
    end
  endfunction

  function automatic logic signed [TERM_W-1:0] apply_weight(
    input logic signed [PSUM_W-1:0] v, input logic signed [2:0] w);
    logic signed [TERM_W-1:0] e;
    begin
      e = TERM_W'(v);
      unique case (w)
        3'sd1:   apply_weight = e;
        -3'sd1:  apply_weight = -e;
        3'sd2:   apply_weight = e <<< 1;
        -3'sd2:  apply_weight = -(e <<< 1);
        default: apply_weight = '0;
      endcase
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    begin
      if (v[SUM_W-1] != v[SUM_W-2]) begin
        sat_acc = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        sat_acc = v[ACC_W-1:0];
      end
    end
  endfunction

  det_t bra_mem [MAX_DETS];
  det_t ket_mem [MAX_DETS];

  det_t                     bra_rd;
  det_t                     ket_rd;
  logic [ORB_W-1:0]         op_p, op_q, op_r, op_s;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [2:0]        weight;
  logic signed [TERM_W-1:0] term_re, term_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic                     v1, v2, v3;

  det_t                     wr_entry;
  logic                     slot_ok;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [PSUM_W-1:0] sum_re, sum_im;
  logic signed [SUM_W-1:0]  next_re, next_im;

  assign wr_entry = '{orb_a: req.orbital_first, orb_b: req.orbital_second,
                      re: req.coef_re, im: req.coef_im};
  assign slot_ok  = 32'(req.slot) < 32'(MAX_DETS);
  assign wr_addr  = ADDR_W'(req.slot);

  assign sum_re  = PSUM_W'(p_rr) + PSUM_W'(p_ii);
  assign sum_im  = PSUM_W'(p_ri) - PSUM_W'(p_ir);
  assign next_re = SUM_W'(acc_re) + SUM_W'(term_re);
  assign next_im = SUM_W'(acc_im) + SUM_W'(term_im);

  assign status.busy     = v1 || v2 || v3;
  assign status.res_free = !res_valid || !res_stall;

  // Stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load_bra && slot_ok) begin
      bra_mem[wr_addr] <= wr_entry;
    end
    if (cmd.load_ket && slot_ok) begin
      ket_mem[wr_addr] <= wr_entry;
    end
    bra_rd <= bra_mem[cmd.bra_addr];
    ket_rd <= ket_mem[cmd.ket_addr];
  end

  // Products, weight and weighted terms.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_p <= req.op_p;
      op_q <= req.op_q;
      op_r <= req.op_r;
      op_s <= req.op_s;
    end
    p_rr    <= bra_rd.re * ket_rd.re;
    p_ii    <= bra_rd.im * ket_rd.im;
    p_ri    <= bra_rd.re * ket_rd.im;
    p_ir    <= bra_rd.im * ket_rd.re;
    weight  <= pair_weight(bra_rd, ket_rd, cmd.two_particle, op_p, op_q, op_r, op_s);
    term_re <= apply_weight(sum_re, weight);
    term_im <= apply_weight(sum_im, weight);
  end

  // Pipeline valid bits, accumulator and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      acc_re    <= '0;
      acc_im    <= '0;
      res_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd_valid;
      v2 <= v1;
      v3 <= v2;
      if (cmd.start) begin
        acc_re <= '0;
        acc_im <= '0;
      end else if (v3) begin
        acc_re <= sat_acc(next_re);
        acc_im <= sat_acc(next_im);
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.element_re <= acc_re;
      res.element_im <= acc_im;
    end
  end

  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !(v1 || v2 || v3))
    else $error("query started while pairs were still in flight");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("finished query produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(res_valid && res_stall))
    else $error("result register overwritten while stalled");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (!v3 && !cmd.start) |=> $stable(acc_re) && $stable(acc_im))
    else $error("accumulator changed with no pair arriving");

endmodule

// ----- hdl/pair_density_element_accumulator.sv -----
// Channel    Direction  Payload               Handshake
// request    in         pdea_pkg::req_t req   req_valid / req_stall
// result     out        pdea_pkg::res_t res   res_valid / res_stall
// config     in         cfg_index, cfg_data   cfg_write (no wait)
//
// A query request walks every bra-ket pair, one pair per cycle (no pairs
// when either count is zero), and its result becomes valid once the walk
// is done and the datapath pipeline has drained. Reset is synchronous and
// clears the control state, the configuration registers, the pipeline
// valid bits and the accumulator; the stores hold no reset value.
// A query may be accepted while an earlier result waits; it stalls only at
// its end if the result register is still full.
module pair_density_element_accumulator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  pdea_pkg::req_t                 req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output pdea_pkg::res_t                 res,
  input  logic                           cfg_write,
  input  logic [pdea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdea_pkg::CFG_W-1:0]     cfg_data
);
  import pdea_pkg::*;

  // The controller owns the configuration registers and the pair counters.
  // It holds off new requests for the whole walk of a query, issues one
  // bra address and one ket address each cycle, and then waits until the
  // datapath pipeline has drained and the result register is free.
  ctl_cmd_t   cmd;
  dp_status_t status;

  pdea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .command   (req.command),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds both stores, reads one entry of each per cycle,
  // forms the four coefficient products and the pattern weight, scales the
  // complex term by the weight, and adds it into a saturating 48-bit
  // accumulator. The finished sum moves into the result register, which
  // keeps it stable until the result channel takes it.
  pdea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
